### hw/rtl/slcfr_pkg.sv
// Shared constants, types and helpers of the sync/length/checksum frame receiver.
package slcfr_pkg;

	// Frame geometry
	localparam int FRAME_CAPACITY = 16;
	localparam int FRAME_OVERHEAD = 4;
	localparam int PAY_DEPTH      = FRAME_CAPACITY - FRAME_OVERHEAD;
	localparam int IDX_W          = $clog2(PAY_DEPTH + 1);
	localparam int ADDR_W         = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

	localparam logic [7:0] SYNC_VALUE   = 8'hAA;
	localparam logic [8:0] PAY_DEPTH_9  = 9'(PAY_DEPTH);

	// Result status codes
	localparam logic [1:0] STATUS_GOOD    = 2'd0;
	localparam logic [1:0] STATUS_SUM_ERR = 2'd1;
	localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

	// Stream widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_CMD,
		ST_LEN,
		ST_PAY,
		ST_READ
	} state_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_LEN_ERR,
		EMIT_SUM_ERR,
		EMIT_EMPTY,
		EMIT_PAY
	} emit_t;

	// Controller to datapath
	typedef struct packed {
		logic  take;
		logic  start;
		logic  add_sum;
		logic  load_cmd;
		logic  load_len;
		logic  load_pay;
		logic  rd_start;
		logic  rd_step;
		emit_t emit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sync_hit;
		logic len_big;
		logic len_zero;
		logic pay_done;
		logic sum_ok;
		logic rd_last;
		logic out_free;
	} dp_status_t;

	// Fit a counter value into a 4-bit result field
	function automatic logic [3:0] to_field4(input logic [IDX_W-1:0] v);
		logic [IDX_W+3:0] t;
		t = {4'b0000, v};
		return t[3:0];
	endfunction

endpackage

### hw/rtl/slcfr_ctrl.sv
// Controller state machine of the frame receiver.
module slcfr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  slcfr_pkg::dp_status_t  sts,
	output slcfr_pkg::ctrl_cmd_t   cmd
);
	import slcfr_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   fire;

	// Take a word only outside readout and when the output register can load
	assign fire = s_tvalid && (state_q != ST_READ) && sts.out_free;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (fire && sts.sync_hit) state_nxt = ST_CMD;
			end
			ST_CMD: begin
				if (fire) state_nxt = ST_LEN;
			end
			ST_LEN: begin
				if (fire) state_nxt = sts.len_big ? ST_HUNT : ST_PAY;
			end
			ST_PAY: begin
				if (fire && sts.pay_done) begin
					if (sts.sum_ok && !sts.len_zero) state_nxt = ST_READ;
					else state_nxt = ST_HUNT;
				end
			end
			ST_READ: begin
				if (sts.out_free && sts.rd_last) state_nxt = ST_HUNT;
			end
			default: state_nxt = ST_HUNT;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.emit     = EMIT_NONE;
		cmd.take     = (state_q != ST_READ) && sts.out_free;
		unique case (state_q)
			ST_HUNT: begin
				if (fire && sts.sync_hit) cmd.start = 1'b1;
			end
			ST_CMD: begin
				if (fire) begin
					cmd.load_cmd = 1'b1;
					cmd.add_sum  = 1'b1;
				end
			end
			ST_LEN: begin
				if (fire) begin
					cmd.load_len = 1'b1;
					if (sts.len_big) cmd.emit = EMIT_LEN_ERR;
					else cmd.add_sum = 1'b1;
				end
			end
			ST_PAY: begin
				if (fire) begin
					if (!sts.pay_done) begin
						cmd.load_pay = 1'b1;
						cmd.add_sum  = 1'b1;
					end else if (!sts.sum_ok) begin
						cmd.emit = EMIT_SUM_ERR;
					end else if (sts.len_zero) begin
						cmd.emit = EMIT_EMPTY;
					end else begin
						cmd.rd_start = 1'b1;
					end
				end
			end
			ST_READ: begin
				if (sts.out_free) begin
					cmd.emit    = EMIT_PAY;
					cmd.rd_step = 1'b1;
				end
			end
			default: begin
				cmd.take = 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A result is only produced when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EMIT_NONE) |-> sts.out_free)
		else $error("result emitted while output register busy");

	// Readout never runs for an empty payload
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !sts.len_zero)
		else $error("readout with zero length");

	// A good checksum on a nonempty frame leads into readout
	a_chk_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAY && fire && sts.pay_done && sts.sum_ok && !sts.len_zero)
		|=> (state_q == ST_READ))
		else $error("good frame did not enter readout");
`endif

endmodule

### hw/rtl/slcfr_dp.sv
// Datapath of the frame receiver: running sum, frame fields, payload store, output register.
module slcfr_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [7:0]                           rx_byte,
	input  slcfr_pkg::ctrl_cmd_t                 cmd,
	output slcfr_pkg::dp_status_t                sts,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [1:0]                           out_status,
	output logic [7:0]                           out_command,
	output logic [3:0]                           out_length,
	output logic [7:0]                           out_byte,
	output logic [3:0]                           out_index,
	output logic                                 out_last
);
	import slcfr_pkg::*;

	logic [7:0]       sum_q;
	logic [7:0]       cmd_q;
	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       store_q [PAY_DEPTH];
	logic [IDX_W:0]   idx_inc;

	logic             valid_q;
	logic [1:0]       status_q;
	logic [7:0]       command_q;
	logic [3:0]       length_q;
	logic [7:0]       byte_q;
	logic [3:0]       index_q;
	logic             last_q;

	assign idx_inc = {1'b0, idx_q} + 1'b1;

	// Status toward the controller
	always_comb begin
		sts.sync_hit = (rx_byte == SYNC_VALUE);
		sts.len_big  = ({1'b0, rx_byte} > PAY_DEPTH_9);
		sts.len_zero = (len_q == '0);
		sts.pay_done = (idx_q == len_q);
		sts.sum_ok   = (rx_byte == sum_q);
		sts.rd_last  = (idx_inc == {1'b0, len_q});
		sts.out_free = !valid_q || out_ready;
	end

	// Hold running sum and frame header fields
	always_ff @(posedge clk) begin
		if (cmd.start) sum_q <= SYNC_VALUE;
		else if (cmd.add_sum) sum_q <= sum_q + rx_byte;
		if (cmd.load_cmd) cmd_q <= rx_byte;
		if (cmd.load_len) len_q <= rx_byte[IDX_W-1:0];
	end

	// Advance the payload position, used for writing and then for readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_len || cmd.rd_start) begin
			idx_q <= '0;
		end else if (cmd.load_pay || cmd.rd_step) begin
			idx_q <= idx_inc[IDX_W-1:0];
		end
	end

	// Write payload bytes
	always_ff @(posedge clk) begin
		if (cmd.load_pay) store_q[idx_q[ADDR_W-1:0]] <= rx_byte;
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load result fields
	always_ff @(posedge clk) begin
		case (cmd.emit)
			EMIT_LEN_ERR: begin
				status_q  <= STATUS_LEN_ERR;
				command_q <= cmd_q;
				length_q  <= rx_byte[3:0];
				byte_q    <= '0;
				index_q   <= '0;
				last_q    <= 1'b1;
			end
			EMIT_SUM_ERR: begin
				status_q  <= STATUS_SUM_ERR;
				command_q <= cmd_q;
				length_q  <= to_field4(len_q);
				byte_q    <= '0;
				index_q   <= '0;
				last_q    <= 1'b1;
			end
			EMIT_EMPTY: begin
				status_q  <= STATUS_GOOD;
				command_q <= cmd_q;
				length_q  <= to_field4(len_q);
				byte_q    <= '0;
				index_q   <= '0;
				last_q    <= 1'b1;
			end
			EMIT_PAY: begin
				status_q  <= STATUS_GOOD;
				command_q <= cmd_q;
				length_q  <= to_field4(len_q);
				byte_q    <= store_q[idx_q[ADDR_W-1:0]];
				index_q   <= to_field4(idx_q);
				last_q    <= sts.rd_last;
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = valid_q;
	assign out_status  = status_q;
	assign out_command = command_q;
	assign out_length  = length_q;
	assign out_byte    = byte_q;
	assign out_index   = index_q;
	assign out_last    = last_q;

`ifndef SYNTHESIS
	// Readout position stays inside the declared payload
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EMIT_PAY) |-> (idx_q < len_q))
		else $error("payload read beyond declared length");
`endif

endmodule

### hw/rtl/sync_length_checksum_frame_receiver.sv
// Top level of the sync/length/checksum frame receiver.
//
// Channel  Dir  Fields (tdata/tuser low bit up)                       Ends on
// s_*      in   tdata: rx_byte[7:0]                                    tvalid & tready
// m_*      out  tdata: command, payload_length, payload_byte,          tvalid & tready
//                      byte_index; tuser: status; tlast: last
//
// Each received word is taken when the output register is free; the
// controller accepts no word while a finished result blocks the output register.
// A good frame reads its payload out of the register store one word per cycle
// while the output register is free, during which s_tready is low.
// Reset clears the controller (hunting for sync), the position counter and
// the output valid; the payload store is not cleared.
module sync_length_checksum_frame_receiver (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [slcfr_pkg::IN_DATA_W-1:0]          s_tdata,  // rx_byte[7:0]
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// command[7:0], payload_length[11:8], payload_byte[19:12], byte_index[23:20]
	output logic [slcfr_pkg::OUT_DATA_W-1:0]         m_tdata,
	output logic [slcfr_pkg::OUT_USER_W-1:0]         m_tuser,  // status[1:0]
	output logic                                     m_tlast
);
	import slcfr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;
	logic [1:0] o_status;
	logic [7:0] o_command;
	logic [3:0] o_length;
	logic [7:0] o_byte;
	logic [3:0] o_index;

	slcfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	slcfr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_status  (o_status),
		.out_command (o_command),
		.out_length  (o_length),
		.out_byte    (o_byte),
		.out_index   (o_index),
		.out_last    (m_tlast)
	);

	// Pack result word
	assign s_tready = cmd.take;
	assign m_tdata  = {o_index, o_byte, o_length, o_command};
	assign m_tuser  = o_status;

endmodule

### bench/testbench.sv
// Self-checking bench for the sync/length/checksum frame receiver.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slcfr_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 40;
	localparam int RANDOM_BYTES = 500;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_SYNC
	} fill_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] command;
		logic [3:0] payload_length;
		logic [7:0] payload_byte;
		logic [3:0] byte_index;
		logic       last;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;   // rx_byte[7:0]
	logic m_tvalid;
	logic m_tready = 1'b1;
	// command[7:0], payload_length[11:8], payload_byte[19:12], byte_index[23:20]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;       // status[1:0]
	logic m_tlast;

	logic [7:0]    rx_bytes_pending[$];
	frame_result_t frame_results_due[$];

	// predicted receiver state
	int         rx_count = 0;
	logic [7:0] rx_sum = '0;
	logic [7:0] rx_cmd = '0;
	logic [7:0] rx_len = '0;
	logic [7:0] rx_payload[PAY_DEPTH];

	int   errors = 0;
	int   idle_cycles = 0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	int   in_wait = 0;
	int   in_count = 0;
	bit   in_quiet = 1'b0;
	int   out_wait = 0;
	int   out_count = 0;
	bit   out_quiet = 1'b0;

	sync_length_checksum_frame_receiver u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Build one result from the current frame header
	function automatic frame_result_t make_result(input logic [1:0] status,
			input logic [7:0] pbyte, input logic [3:0] idx, input logic last);
		frame_result_t r;
		r.status = status;
		r.command = rx_cmd;
		r.payload_length = rx_len[3:0];
		r.payload_byte = pbyte;
		r.byte_index = idx;
		r.last = last;
		return r;
	endfunction

	// Advance the frame decoder by one received word and queue its results
	task automatic decode_rx_byte(input logic [7:0] b);
		int i;
		if (rx_count == 0) begin
			if (b == SYNC_VALUE) begin
				rx_count = 1;
				rx_sum = b;
				rx_len = '0;
			end
		end else if (rx_count == 1) begin
			rx_cmd = b;
			rx_sum = rx_sum + b;
			rx_count = 2;
		end else if (rx_count == 2) begin
			rx_len = b;
			if (int'(b) + FRAME_OVERHEAD > FRAME_CAPACITY) begin
				frame_results_due.push_back(make_result(STATUS_LEN_ERR, 8'h00, 4'h0, 1'b1));
				rx_count = 0;
				rx_sum = '0;
			end else begin
				rx_sum = rx_sum + b;
				rx_count = 3;
			end
		end else if (rx_count < 3 + int'(rx_len)) begin
			if (rx_count - 3 < PAY_DEPTH)
				rx_payload[rx_count - 3] = b;
			rx_sum = rx_sum + b;
			rx_count++;
		end else begin
			// checksum word closes the frame
			if (b != rx_sum) begin
				frame_results_due.push_back(make_result(STATUS_SUM_ERR, 8'h00, 4'h0, 1'b1));
			end else if (rx_len == 0) begin
				frame_results_due.push_back(make_result(STATUS_GOOD, 8'h00, 4'h0, 1'b1));
			end else begin
				for (i = 0; i < int'(rx_len) && i < PAY_DEPTH; i++)
					frame_results_due.push_back(make_result(STATUS_GOOD, rx_payload[i],
						4'(i), (i + 1 == int'(rx_len))));
			end
			rx_count = 0;
			rx_sum = '0;
		end
	endtask

	// Queue one frame; cut > 0 stops it after that many payload words
	function automatic int queue_frame(input logic [7:0] cmd, input logic [7:0] len,
			input fill_t fill, input bit corrupt, input int cut);
		logic [7:0] sum;
		logic [7:0] pb;
		int k;
		rx_bytes_pending.push_back(SYNC_VALUE);
		rx_bytes_pending.push_back(cmd);
		rx_bytes_pending.push_back(len);
		sum = SYNC_VALUE + cmd;
		if (int'(len) > PAY_DEPTH)
			return 3;
		sum = sum + len;
		for (k = 0; k < int'(len); k++) begin
			if (cut > 0 && k == cut)
				return 3 + k;
			case (fill)
				FILL_ZERO: pb = 8'h00;
				FILL_ONES: pb = 8'hFF;
				FILL_SYNC: pb = SYNC_VALUE;
				default:   pb = 8'($urandom_range(0, 255));
			endcase
			rx_bytes_pending.push_back(pb);
			sum = sum + pb;
		end
		rx_bytes_pending.push_back(corrupt ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum);
		return 4 + int'(len);
	endfunction

	// Report one field that differs from its expectation
	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Present input words with random gaps
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (in_wait > 0) begin
				s_tvalid <= 1'b0;
				in_wait--;
			end else if (rx_bytes_pending.size() > 0) begin
				s_tdata <= rx_bytes_pending.pop_front();
				s_tvalid <= 1'b1;
				if (in_count % 40 == 0)
					in_quiet = ($urandom_range(0, 3) == 0);
				in_count++;
				in_wait = in_quiet ? 0 : $urandom_range(0, 3);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Stall the result side after each accepted word
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if (out_count % 40 == 0)
					out_quiet = ($urandom_range(0, 3) == 0);
				out_count++;
				out_wait = out_quiet ? 0 : $urandom_range(0, 3);
				m_tready <= (out_wait == 0);
			end else if (out_wait > 0) begin
				out_wait--;
				m_tready <= (out_wait == 0);
			end
		end
	end

	// Track accepted words on both sides, check results, watch for a hang
	always @(posedge clk) begin
		frame_result_t exp_r;
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;
			out_taken <= m_tvalid && m_tready;
			if (s_tvalid && s_tready)
				decode_rx_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				if (frame_results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual tdata=%h tuser=%0d last=%0d",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					exp_r = frame_results_due.pop_front();
					check_field("status", exp_r.status, m_tuser);
					check_field("command", exp_r.command, m_tdata[7:0]);
					check_field("payload_length", exp_r.payload_length, m_tdata[11:8]);
					check_field("payload_byte", exp_r.payload_byte, m_tdata[19:12]);
					check_field("byte_index", exp_r.byte_index, m_tdata[23:20]);
					check_field("last", exp_r.last, m_tlast);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Reset, fill the stimulus queue, then drain and report
	initial begin
		int n_bytes;
		int kind;
		int len;
		fill_t fill;
		n_bytes = 0;

		// directed: noise, empty frames, oversize lengths, sync value as data
		rx_bytes_pending.push_back(8'h00);
		rx_bytes_pending.push_back(8'hFF);
		rx_bytes_pending.push_back(8'h55);
		void'(queue_frame(8'h00, 8'd0, FILL_RANDOM, 1'b0, 0));
		void'(queue_frame(8'hFF, 8'd13, FILL_RANDOM, 1'b0, 0));
		void'(queue_frame(8'h5A, 8'd255, FILL_RANDOM, 1'b0, 0));
		void'(queue_frame(8'h33, 8'd0, FILL_RANDOM, 1'b1, 0));
		void'(queue_frame(8'hAA, 8'd1, FILL_SYNC, 1'b0, 0));
		void'(queue_frame(8'hAA, 8'd2, FILL_ONES, 1'b0, 0));

		// random: mostly good frames, some broken ones and noise
		while (n_bytes < RANDOM_BYTES) begin
			kind = $urandom_range(0, 99);
			len = ($urandom_range(0, 7) == 0) ? PAY_DEPTH : $urandom_range(0, PAY_DEPTH);
			case ($urandom_range(0, 15))
				0:       fill = FILL_ZERO;
				1:       fill = FILL_ONES;
				2:       fill = FILL_SYNC;
				default: fill = FILL_RANDOM;
			endcase
			if (kind < 78) begin
				n_bytes += queue_frame(8'($urandom_range(0, 255)), 8'(len), fill, 1'b0, 0);
			end else if (kind < 86) begin
				n_bytes += queue_frame(8'($urandom_range(0, 255)), 8'(len), fill, 1'b1, 0);
			end else if (kind < 92) begin
				n_bytes += queue_frame(8'($urandom_range(0, 255)),
					8'($urandom_range(PAY_DEPTH + 1, 255)), fill, 1'b0, 0);
			end else if (kind < 96) begin
				if (len < 2)
					len = 2;
				n_bytes += queue_frame(8'($urandom_range(0, 255)), 8'(len), fill, 1'b0,
					$urandom_range(1, len - 1));
			end else begin
				repeat ($urandom_range(1, 4))
					rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
			end
		end
		// noise may leave a frame open: close it with enough good frames
		repeat (2)
			void'(queue_frame(8'h0F, 8'd0, FILL_RANDOM, 1'b0, 0));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rx_bytes_pending.size() > 0 || s_tvalid || frame_results_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
